### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/rbpa_pkg.sv
`default_nettype none

package rbpa_pkg;

  localparam int unsigned GROUP_SIZE_DEF = 10;
  localparam int unsigned GROUPS_DEF     = 8;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned SQ_W    = 2 * VALUE_W;
  localparam int unsigned SUM_W   = 36;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned GRP_W   = 3;
  localparam int unsigned REM_W   = 20;
  localparam int unsigned STEP_W  = 4;

  // The sum is divided in 12-bit digits. The remainder carried between digits
  // is below GROUP_SIZE, so it fits in 4 bits and one digit step sees 16 bits.
  localparam int unsigned DIGIT_W    = 12;
  localparam int unsigned DIV_DIGITS = SUM_W / DIGIT_W;
  localparam int unsigned DREM_W     = 4;
  localparam int unsigned DIGIT_IN_W = DREM_W + DIGIT_W;

  // Reciprocal of GROUP_SIZE scaled by 2^20; exact for 16-bit dividends and
  // divisors from 2 up to 16.
  localparam int unsigned RECIP_SH = DIGIT_IN_W + DREM_W;
  localparam int unsigned RECIP_W  = 20;
  localparam int unsigned PROD_W   = DIGIT_IN_W + RECIP_W;

  // Two division steps per quotient digit, one root bit per root step.
  localparam int unsigned DIV_STEPS  = 2 * DIV_DIGITS;
  localparam int unsigned ROOT_STEPS = VALUE_W;

  localparam int unsigned OUT_W   = 24;
  localparam int unsigned OUT_PAD = OUT_W - VALUE_W - GRP_W;

  typedef struct packed {
    logic load;  // capture the incoming level
    logic add;   // add its square into the group sum
  } acc_ctrl_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum_total;  // group sum including the captured square
    logic             closing;    // captured level completes the group
    logic [GRP_W-1:0] grp;        // index of the current group
    logic             last;       // current group is the last of the frame
  } acc_stat_t;

endpackage

`default_nettype wire

### rtl/rms_block_power_average.sv
// Root mean square over groups of short-window RMS levels.
// Input channel s_*: one word per RMS level, unsigned Q8.8 in s_tdata[15:0].
// Output channel m_*: one word per completed group of GROUP_SIZE levels:
// m_tdata[15:0] is the Q8.8 level, m_tdata[18:16] the group index within
// a frame of GROUPS groups, and m_tlast marks the last group of the frame.
// A level that does not complete its group is captured, then squared and
// added, before s_tready rises again. The level that completes a group
// passes capture, square and add, division, square root and the output
// register before the result word is valid: the sum is divided by GROUP_SIZE
// as three 12-bit digits, each one step of reciprocal multiply and one step
// for the remainder on the shared 20-bit compare-subtract unit; that unit
// then yields the 16 bits of the floor square root, one per cycle.
// The result sits in an output register; the next level is accepted while
// it waits. If a further group completes before the receiver takes the
// word, the block holds the new result and s_tready stays low until then.
// Reset clears the group sum, the item count, the group index and the
// output valid; the block is ready in the first cycle after reset.
`default_nettype none

module rms_block_power_average #(
  parameter int unsigned GROUP_SIZE = rbpa_pkg::GROUP_SIZE_DEF,
  parameter int unsigned GROUPS     = rbpa_pkg::GROUPS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [rbpa_pkg::VALUE_W-1:0]   s_tdata,  // [15:0] rms_value
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic      [rbpa_pkg::OUT_W-1:0]     m_tdata,  // [15:0] level, [18:16] group_index
  output logic                                m_tlast   // last_group
);

  localparam logic [rbpa_pkg::RECIP_W-1:0] RECIP = rbpa_pkg::RECIP_W'(
    ((64'd1 << rbpa_pkg::RECIP_SH) + 64'(GROUP_SIZE) - 64'd1) / 64'(GROUP_SIZE));

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SQR  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_ROOT = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state;

  rbpa_pkg::acc_ctrl_t acc_ctrl;
  rbpa_pkg::acc_stat_t acc_stat;

  logic [rbpa_pkg::SUM_W-1:0]      work;
  logic [rbpa_pkg::REM_W-1:0]      rem;
  logic [rbpa_pkg::VALUE_W-1:0]    root;
  logic [rbpa_pkg::STEP_W-1:0]     step;
  logic [rbpa_pkg::GRP_W-1:0]      pend_grp;
  logic                            pend_last;

  logic [rbpa_pkg::DIGIT_IN_W-1:0] digit_in;
  logic [rbpa_pkg::PROD_W-1:0]     recip_prod;
  logic [rbpa_pkg::DIGIT_W-1:0]    quot_digit;
  logic [rbpa_pkg::DIGIT_W-1:0]    qdig;
  logic [rbpa_pkg::REM_W-1:0]      qd_prod;

  logic [rbpa_pkg::REM_W-1:0]      unit_a;
  logic [rbpa_pkg::REM_W-1:0]      unit_b;
  logic [rbpa_pkg::REM_W-1:0]      unit_diff;
  logic                            unit_ge;

  logic [rbpa_pkg::VALUE_W-1:0]    level_q;
  logic [rbpa_pkg::GRP_W-1:0]      grp_q;
  logic                            last_q;
  logic                            out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = ~m_tvalid | m_tready;

  assign acc_ctrl.load = s_tvalid & s_tready;
  assign acc_ctrl.add  = (state == ST_SQR);

  rbpa_accum #(
    .GROUP_SIZE (GROUP_SIZE),
    .GROUPS     (GROUPS)
  ) u_accum (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (acc_ctrl),
    .value (s_tdata),
    .stat  (acc_stat)
  );

  // One division digit: the carried remainder above the next 12 dividend bits,
  // times the scaled reciprocal, gives the quotient digit in bits [31:20].
  assign digit_in   = {rem[rbpa_pkg::DREM_W-1:0],
                       work[rbpa_pkg::SUM_W-1 -: rbpa_pkg::DIGIT_W]};
  assign recip_prod = {{rbpa_pkg::RECIP_W{1'b0}}, digit_in}
                    * {{rbpa_pkg::DIGIT_IN_W{1'b0}}, RECIP};
  assign quot_digit = recip_prod[rbpa_pkg::RECIP_SH +: rbpa_pkg::DIGIT_W];
  assign qd_prod    = {{(rbpa_pkg::REM_W - rbpa_pkg::DIGIT_W){1'b0}}, qdig}
                    * rbpa_pkg::REM_W'(GROUP_SIZE);

  // During division the unit forms the digit remainder; the root brings down
  // two radicand bits and tries the next root bit with (root << 2) | 1.
  always_comb begin
    if (state == ST_DIV) begin
      unit_a = {{(rbpa_pkg::REM_W - rbpa_pkg::DIGIT_IN_W){1'b0}}, digit_in};
      unit_b = qd_prod;
    end else begin
      unit_a = {rem[rbpa_pkg::REM_W-3:0], work[31:30]};
      unit_b = {{(rbpa_pkg::REM_W - rbpa_pkg::VALUE_W - 2){1'b0}}, root, 2'b01};
    end
  end

  rbpa_cmpsub u_cmpsub (
    .a    (unit_a),
    .b    (unit_b),
    .diff (unit_diff),
    .ge   (unit_ge)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_SQR;
          end
        end
        ST_SQR: begin
          state <= acc_stat.closing ? ST_DIV : ST_IDLE;
        end
        ST_DIV: begin
          if (step == '0) begin
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (step == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state) inside
      ST_SQR: begin
        work      <= acc_stat.sum_total;
        rem       <= '0;
        step      <= rbpa_pkg::STEP_W'(rbpa_pkg::DIV_STEPS - 1);
        pend_grp  <= acc_stat.grp;
        pend_last <= acc_stat.last;
      end
      ST_DIV: begin
        // Odd steps register the quotient digit; even steps shift the digit into the
        // low end of work and, all but the last, keep the remainder.
        if (step[0]) begin
          qdig <= quot_digit;
          step <= step - 1'b1;
        end else if (step == '0) begin
          work <= {work[rbpa_pkg::SUM_W-rbpa_pkg::DIGIT_W-1:0], qdig};
          rem  <= '0;
          root <= '0;
          step <= rbpa_pkg::STEP_W'(rbpa_pkg::ROOT_STEPS - 1);
        end else begin
          work <= {work[rbpa_pkg::SUM_W-rbpa_pkg::DIGIT_W-1:0], qdig};
          rem  <= unit_diff;
          step <= step - 1'b1;
        end
      end
      ST_ROOT: begin
        work <= {work[rbpa_pkg::SUM_W-3:0], 2'b00};
        rem  <= unit_ge ? unit_diff : unit_a;
        root <= {root[rbpa_pkg::VALUE_W-2:0], unit_ge};
        step <= step - 1'b1;
      end
      ST_IDLE, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      level_q <= root;
      grp_q   <= pend_grp;
      last_q  <= pend_last;
    end
  end

  assign m_tdata = {{rbpa_pkg::OUT_PAD{1'b0}}, grp_q, level_q};
  assign m_tlast = last_q;

endmodule

`default_nettype wire

### rtl/rbpa_cmpsub.sv
`default_nettype none

module rbpa_cmpsub (
  input  wire logic [rbpa_pkg::REM_W-1:0] a,
  input  wire logic [rbpa_pkg::REM_W-1:0] b,
  output logic      [rbpa_pkg::REM_W-1:0] diff,
  output logic                            ge
);

  logic [rbpa_pkg::REM_W:0] wide;

  // The extra top bit is the borrow; no borrow means a >= b.
  assign wide = {1'b0, a} - {1'b0, b};
  assign diff = wide[rbpa_pkg::REM_W-1:0];
  assign ge   = ~wide[rbpa_pkg::REM_W];

endmodule

`default_nettype wire

### rtl/rbpa_accum.sv
`default_nettype none

module rbpa_accum #(
  parameter int unsigned GROUP_SIZE = rbpa_pkg::GROUP_SIZE_DEF,
  parameter int unsigned GROUPS     = rbpa_pkg::GROUPS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire rbpa_pkg::acc_ctrl_t               ctrl,
  input  wire logic [rbpa_pkg::VALUE_W-1:0]      value,
  output rbpa_pkg::acc_stat_t                    stat
);

  logic [rbpa_pkg::VALUE_W-1:0] x;
  logic [rbpa_pkg::SQ_W-1:0]    sq;
  logic [rbpa_pkg::SUM_W-1:0]   sum;
  logic [rbpa_pkg::CNT_W-1:0]   count;
  logic [rbpa_pkg::GRP_W-1:0]   grp;

  assign sq = x * x;

  assign stat.sum_total = sum + {{(rbpa_pkg::SUM_W - rbpa_pkg::SQ_W){1'b0}}, sq};
  assign stat.closing   = (count == rbpa_pkg::CNT_W'(GROUP_SIZE - 1));
  assign stat.grp       = grp;
  assign stat.last      = (grp == rbpa_pkg::GRP_W'(GROUPS - 1));

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
      grp   <= '0;
    end else if (ctrl.add) begin
      if (stat.closing) begin
        sum   <= '0;
        count <= '0;
        grp   <= stat.last ? '0 : grp + 1'b1;
      end else begin
        sum   <= stat.sum_total;
        count <= count + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/rbpa_checker.sv
`default_nettype none
`include "assert_macros.svh"

module rbpa_checker #(
  parameter int unsigned GROUPS = rbpa_pkg::GROUPS_DEF
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_tvalid,
  input wire logic                         s_tready,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [rbpa_pkg::OUT_W-1:0]   m_tdata,
  input wire logic                         m_tlast
);

  logic [rbpa_pkg::GRP_W-1:0] out_grp;

  assign out_grp = m_tdata[rbpa_pkg::VALUE_W +: rbpa_pkg::GRP_W];

  // Every accepted level makes the block busy: s_tready drops once the word is taken.
  `ASSERT_CLK_RST(a_busy_after_accept, clk, rst, s_tvalid && s_tready |=> !s_tready, "ready did not drop after an accepted word")

  // A stalled result word stays valid and unchanged.
  `ASSERT_CLK_RST(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result word changed")

  // The frame marker and the group index agree, and the index stays in range.
  `ASSERT_CLK_RST(a_last_index, clk, rst, m_tvalid |-> (m_tlast == (out_grp == rbpa_pkg::GRP_W'(GROUPS - 1))) && (out_grp <= rbpa_pkg::GRP_W'(GROUPS - 1)), "group index and last flag disagree")

  // No result is pending right after reset.
  `ASSERT_CLK(a_reset_empty, clk, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind rms_block_power_average rbpa_checker #(
  .GROUPS (GROUPS)
) u_rbpa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned GROUP_SIZE  = rbpa_pkg::GROUP_SIZE_DEF;
  localparam int unsigned GROUPS      = rbpa_pkg::GROUPS_DEF;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned IDLE_PCT    = 23;

  typedef struct packed {
    logic [rbpa_pkg::VALUE_W-1:0] level;
    logic [rbpa_pkg::GRP_W-1:0]   grp;
    logic                         last;
  } group_level_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [rbpa_pkg::VALUE_W-1:0] s_tdata = '0;  // [15:0] rms_value
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [rbpa_pkg::OUT_W-1:0]   m_tdata;       // [15:0] level, [18:16] group_index
  logic                         m_tlast;       // last_group

  // Levels waiting to be offered, and group results still to arrive.
  logic [rbpa_pkg::VALUE_W-1:0] pend_levels[$];
  group_level_t                 level_q[$];

  // Running state of the group accumulation.
  logic [rbpa_pkg::SUM_W-1:0]   sq_sum = '0;
  int unsigned                  in_group = 0;
  logic [rbpa_pkg::GRP_W-1:0]   grp_idx = '0;

  logic                         no_idle = 1'b0;
  logic                         hold_req = 1'b0;
  logic                         hold_used;
  int unsigned                  hold_cnt;
  int unsigned                  stall_cycles = 0;
  int unsigned                  mismatch_count = 0;
  group_level_t                 want;

  rms_block_power_average DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [rbpa_pkg::VALUE_W-1:0] floor_root(input logic [31:0] v);
    logic [rbpa_pkg::VALUE_W-1:0] r;
    logic [rbpa_pkg::VALUE_W-1:0] t;
    r = '0;
    for (int b = rbpa_pkg::VALUE_W - 1; b >= 0; b--) begin
      t = r | (16'd1 << b);
      if ({16'd0, t} * {16'd0, t} <= v) r = t;
    end
    return r;
  endfunction

  // Adds one level into the group; a completed group yields its expected result.
  task automatic accumulate_level(input logic [rbpa_pkg::VALUE_W-1:0] x);
    logic [rbpa_pkg::SUM_W-1:0] mean;
    group_level_t               res;
    sq_sum = sq_sum + rbpa_pkg::SUM_W'(x) * rbpa_pkg::SUM_W'(x);
    in_group++;
    if (in_group == GROUP_SIZE) begin
      mean      = sq_sum / GROUP_SIZE;
      res.level = floor_root(mean[31:0]);
      res.grp   = grp_idx;
      res.last  = (grp_idx == GROUPS - 1);
      level_q.push_back(res);
      sq_sum    = '0;
      in_group  = 0;
      grp_idx   = (grp_idx == GROUPS - 1) ? '0 : grp_idx + 1'b1;
    end
  endtask

  function automatic logic [rbpa_pkg::VALUE_W-1:0] random_level();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return rbpa_pkg::VALUE_W'($urandom_range(255));
      3: return rbpa_pkg::VALUE_W'($urandom_range(65535, 65000));
      default: return rbpa_pkg::VALUE_W'($urandom);
    endcase
  endfunction

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) pend_levels.push_back(random_level());
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pend_levels.size() != 0 || s_tvalid || level_q.size() != 0);
  endtask

  // Sender: a word stays on the bus until taken.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) accumulate_level(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (pend_levels.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pend_levels.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_cnt  <= 0;
      hold_used <= 1'b0;
    end else if (hold_req && !hold_used) begin
      hold_used <= 1'b1;
      hold_cnt  <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (level_q.size() == 0) begin
        $error("unexpected result word: level %0d group_index %0d last_group %0d",
               m_tdata[15:0], m_tdata[18:16], m_tlast);
        mismatch_count++;
      end else begin
        want = level_q.pop_front();
        if (m_tdata[15:0] !== want.level) begin
          $error("level: expected %0d, actual %0d", want.level, m_tdata[15:0]);
          mismatch_count++;
        end
        if (m_tdata[18:16] !== want.grp) begin
          $error("group_index: expected %0d, actual %0d", want.grp, m_tdata[18:16]);
          mismatch_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last_group: expected %0d, actual %0d", want.last, m_tlast);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A group at full scale, then a group of corner values.
    repeat (GROUP_SIZE) pend_levels.push_back('1);
    pend_levels.push_back(16'h0000);
    pend_levels.push_back(16'h0001);
    pend_levels.push_back(16'h0002);
    pend_levels.push_back(16'h00ff);
    pend_levels.push_back(16'h0100);
    pend_levels.push_back(16'h8000);
    pend_levels.push_back(16'h7fff);
    pend_levels.push_back(16'haaaa);
    pend_levels.push_back(16'h5555);
    pend_levels.push_back(16'hfffe);
    wait_drained();

    push_random(300);
    wait_drained();

    // The receiver stops for a long while so both result slots fill.
    hold_req = 1'b1;
    push_random(200);
    wait_drained();

    no_idle = 1'b1;
    push_random(300);
    wait_drained();
    no_idle = 1'b0;

    push_random(700);
    wait_drained();
    repeat (100) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### rms_block_power_average.f
+incdir+rtl
rtl/rbpa_pkg.sv
rtl/rbpa_cmpsub.sv
rtl/rbpa_accum.sv
rtl/rms_block_power_average.sv
rtl/rbpa_checker.sv
tb/sv/tb_top.sv
